>>> design/hud_pkg.sv
// ----------------------------------------------------------------------------
// hud_pkg
// Shared types and constants for the HCI UART packet deframer.
// ----------------------------------------------------------------------------
package hud_pkg;

    // Packet kind codes as seen on the result port
    localparam logic [2:0] KIND_COMMAND = 3'd0;
    localparam logic [2:0] KIND_ACL     = 3'd1;
    localparam logic [2:0] KIND_SYNC    = 3'd2;
    localparam logic [2:0] KIND_EVENT   = 3'd3;
    localparam logic [2:0] KIND_ISO     = 3'd4;
    localparam logic [2:0] KIND_DROPPED = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] CFG_COMMAND = 3'd0;
    localparam logic [2:0] CFG_ACL     = 3'd1;
    localparam logic [2:0] CFG_SYNC    = 3'd2;
    localparam logic [2:0] CFG_EVENT   = 3'd3;
    localparam logic [2:0] CFG_ISO     = 3'd4;

    // Reset values of the type indicator codes
    localparam logic [7:0] RST_COMMAND = 8'h01;
    localparam logic [7:0] RST_ACL     = 8'h02;
    localparam logic [7:0] RST_SYNC    = 8'h03;
    localparam logic [7:0] RST_EVENT   = 8'h04;
    localparam logic [7:0] RST_ISO     = 8'h05;

    // ISO length field is 14 bits wide
    localparam logic [15:0] ISO_LEN_MASK = 16'h3fff;

    // Deframer phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_HEADER  = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    // Type indicator codes from the configuration registers
    typedef struct packed {
        logic [7:0] code_command;
        logic [7:0] code_acl;
        logic [7:0] code_sync;
        logic [7:0] code_event;
        logic [7:0] code_iso;
    } t_codes;

    // One result transaction
    typedef struct packed {
        logic [2:0] packet_kind;
        logic [7:0] out_byte;
        logic       first_of_packet;
        logic       last_of_packet;
    } t_result;

endpackage

>>> design/hud_cfg_regs.sv
// ----------------------------------------------------------------------------
// hud_cfg_regs
// Type indicator code registers, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module hud_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [7:0]     i_cfg_data,
    output hud_pkg::t_codes o_codes
);
    import hud_pkg::*;

    t_codes r_codes;

    // Always able to take a write
    assign o_cfg_ready = 1'b1;

    // Register file; indexes above the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.code_command <= RST_COMMAND;
            r_codes.code_acl     <= RST_ACL;
            r_codes.code_sync    <= RST_SYNC;
            r_codes.code_event   <= RST_EVENT;
            r_codes.code_iso     <= RST_ISO;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COMMAND: r_codes.code_command <= i_cfg_data;
                CFG_ACL:     r_codes.code_acl     <= i_cfg_data;
                CFG_SYNC:    r_codes.code_sync    <= i_cfg_data;
                CFG_EVENT:   r_codes.code_event   <= i_cfg_data;
                CFG_ISO:     r_codes.code_iso     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_codes = r_codes;

endmodule

>>> design/hud_parse.sv
// ----------------------------------------------------------------------------
// hud_parse
// Framing state and the single-pass decode of one stream byte.
// ----------------------------------------------------------------------------
module hud_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    input  hud_pkg::t_codes  i_codes,
    output logic             o_has_result,
    output hud_pkg::t_result o_result
);
    import hud_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [2:0]  r_kind,   n_kind;
    logic [1:0]  r_pos,    n_pos;
    logic [7:0]  r_len_lo, n_len_lo;
    logic [15:0] r_rem,    n_rem;

    logic [1:0]  last_pos;
    logic        is_long;
    logic [15:0] len;
    logic [15:0] left;

    // Header shape of the current packet kind
    always_comb begin
        is_long = 1'b0;
        case (r_kind)
            KIND_EVENT:             last_pos = 2'd1;
            KIND_COMMAND, KIND_SYNC: last_pos = 2'd2;
            default: begin
                last_pos = 2'd3;
                is_long  = 1'b1;
            end
        endcase
    end

    // Decode of one byte against the current state
    always_comb begin
        n_phase  = r_phase;
        n_kind   = r_kind;
        n_pos    = r_pos;
        n_len_lo = r_len_lo;
        n_rem    = r_rem;
        len      = 16'd0;
        left     = 16'd0;
        o_has_result = 1'b1;
        o_result.packet_kind     = r_kind;
        o_result.out_byte        = i_byte;
        o_result.first_of_packet = 1'b0;
        o_result.last_of_packet  = 1'b0;

        case (r_phase)
            PH_HEADER: begin
                o_result.first_of_packet = (r_pos == 2'd0);
                if (is_long && r_pos == 2'd2) begin
                    n_len_lo = i_byte;
                end
                if (r_pos == last_pos) begin
                    if (is_long) begin
                        len = {i_byte, r_len_lo};
                        if (r_kind == KIND_ISO) begin
                            len = len & ISO_LEN_MASK;
                        end
                    end else begin
                        len = {8'd0, i_byte};
                    end
                    n_pos = 2'd0;
                    n_rem = len;
                    if (len == 16'd0) begin
                        n_phase = PH_IDLE;
                        o_result.last_of_packet = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end else begin
                    n_pos = r_pos + 2'd1;
                end
            end
            PH_PAYLOAD: begin
                left  = (r_rem != 16'd0) ? (r_rem - 16'd1) : 16'd0;
                n_rem = left;
                if (left == 16'd0) begin
                    n_phase = PH_IDLE;
                    o_result.last_of_packet = 1'b1;
                end
            end
            default: begin
                // Type indicator search, first match wins
                n_phase = PH_HEADER;
                n_pos    = 2'd0;
                n_len_lo = 8'd0;
                n_rem    = 16'd0;
                o_has_result = 1'b0;
                if (i_byte == i_codes.code_command) begin
                    n_kind = KIND_COMMAND;
                end else if (i_byte == i_codes.code_acl) begin
                    n_kind = KIND_ACL;
                end else if (i_byte == i_codes.code_sync) begin
                    n_kind = KIND_SYNC;
                end else if (i_byte == i_codes.code_event) begin
                    n_kind = KIND_EVENT;
                end else if (i_byte == i_codes.code_iso) begin
                    n_kind = KIND_ISO;
                end else begin
                    // Stray byte: pass it on as dropped, keep searching
                    n_phase  = PH_IDLE;
                    n_pos    = r_pos;
                    n_len_lo = r_len_lo;
                    n_rem    = r_rem;
                    o_has_result = 1'b1;
                    o_result.packet_kind = KIND_DROPPED;
                end
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_kind   <= KIND_COMMAND;
            r_pos    <= 2'd0;
            r_len_lo <= 8'd0;
            r_rem    <= 16'd0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_kind   <= n_kind;
            r_pos    <= n_pos;
            r_len_lo <= n_len_lo;
            r_rem    <= n_rem;
        end
    end

    // A payload always has bytes left to come
    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_rem != 16'd0)
        else $error("payload phase with zero remaining count");

    // Header position stays inside the header of the current kind
    a_pos_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEADER |-> r_pos <= last_pos)
        else $error("header position past end of header");

    // Final payload byte returns the deframer to the indicator search
    a_payload_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_phase == PH_PAYLOAD && r_rem == 16'd1 |=> r_phase == PH_IDLE)
        else $error("payload end did not return to indicator search");

endmodule

>>> design/hud_out_reg.sv
// ----------------------------------------------------------------------------
// hud_out_reg
// Result register on the output channel, decoupling it from the decode.
// ----------------------------------------------------------------------------
module hud_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  hud_pkg::t_result i_result,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_stall,
    output hud_pkg::t_result o_result
);
    import hud_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Room for a new result when empty or draining this cycle
    assign o_free = !r_valid || !i_stall;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> design/hci_uart_packet_deframer.sv
// ----------------------------------------------------------------------------
// hci_uart_packet_deframer
// H4-style HCI UART deframer: splits a byte stream into tagged packet bytes.
// ----------------------------------------------------------------------------
// Takes one byte per clock while the output channel does not stall. A byte
// is captured in an input register, decoded in a single pass against the
// framing state, and the resulting transaction lands in an output register,
// from which it is presented on the output. Type indicator bytes that match
// a configured code produce no output transaction; every other byte produces
// exactly one. Output stall back-pressures the input only once both the input
// and output registers hold data. Code registers may be rewritten only while
// no byte is in flight.
module hci_uart_packet_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_stream_byte,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_packet_kind,
    output logic [7:0] o_out_byte,
    output logic       o_first_of_packet,
    output logic       o_last_of_packet,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import hud_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       advance;
    logic       has_result;
    logic       out_free;
    t_codes     codes;
    t_result    dec_result;
    t_result    out_result;

    hud_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_codes     (codes)
    );

    // Held byte moves on if it yields nothing or the output has room
    assign advance = r_in_valid && (!has_result || out_free);
    assign o_stall = r_in_valid && !advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_stream_byte;
        end
    end

    hud_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (advance),
        .i_byte       (r_in_byte),
        .i_codes      (codes),
        .o_has_result (has_result),
        .o_result     (dec_result)
    );

    hud_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && has_result),
        .i_result (dec_result),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_result)
    );

    assign o_packet_kind     = out_result.packet_kind;
    assign o_out_byte        = out_result.out_byte;
    assign o_first_of_packet = out_result.first_of_packet;
    assign o_last_of_packet  = out_result.last_of_packet;

    // Dropped stray bytes never carry packet boundary marks
    a_dropped_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_packet_kind == KIND_DROPPED |-> !o_first_of_packet && !o_last_of_packet)
        else $error("dropped byte carries packet marks");

endmodule

>>> tb/hci_uart_packet_deframer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hci_uart_packet_deframer_checker
// Watches the byte, result and code-write channels of the deframer. It keeps
// its own framing state and code registers, works out the tagged byte that
// each accepted input byte must produce, and compares every result
// transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module hci_uart_packet_deframer_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte input channel
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_byte,
    // result channel
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [2:0] i_packet_kind,
    input  logic [7:0] i_out_byte,
    input  logic       i_first_of_packet,
    input  logic       i_last_of_packet,
    // configuration write channel
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // status for the testbench top
    output int         o_mismatches,
    output int         o_pending
);
    import hud_pkg::*;

    // Predicted framing state and code registers
    logic [7:0]  indicator_code [5];
    t_phase      frame_phase;
    logic [2:0]  frame_kind;
    logic [2:0]  hdr_pos;
    logic [7:0]  len_low;
    logic [15:0] payload_left;

    t_result framed_bytes_q [$];
    int      mismatches = 0;

    function automatic t_result make_result(input logic [2:0] kind, input logic [7:0] value,
                                            input logic first, input logic last);
        t_result r;
        r.packet_kind     = kind;
        r.out_byte        = value;
        r.first_of_packet = first;
        r.last_of_packet  = last;
        return r;
    endfunction

    // Append one predicted transaction at the tail of the queue
    function automatic void queue_result(input t_result r);
        framed_bytes_q.insert(framed_bytes_q.size(), r);
    endfunction

    // Advance the framing state by one byte and queue the tagged byte, if any
    task automatic deframe_byte(input logic [7:0] value);
        int          hdr_len;
        logic        is_first;
        logic [15:0] pkt_len;
        case (frame_phase)
            PH_HEADER: begin
                if (frame_kind == KIND_EVENT)
                    hdr_len = 2;
                else if (frame_kind == KIND_COMMAND || frame_kind == KIND_SYNC)
                    hdr_len = 3;
                else
                    hdr_len = 4;
                is_first = (hdr_pos == 3'd0);
                if (hdr_len == 4 && hdr_pos == 3'd2)
                    len_low = value;
                if (int'(hdr_pos) + 1 >= hdr_len) begin
                    // last header byte: length is now known
                    if (hdr_len == 4) begin
                        pkt_len = {value, len_low};
                        if (frame_kind == KIND_ISO)
                            pkt_len = pkt_len & ISO_LEN_MASK;
                    end else begin
                        pkt_len = {8'h00, value};
                    end
                    hdr_pos = 3'd0;
                    if (pkt_len == 16'd0) begin
                        frame_phase  = PH_IDLE;
                        payload_left = 16'd0;
                        queue_result(make_result(frame_kind, value, is_first, 1'b1));
                    end else begin
                        frame_phase  = PH_PAYLOAD;
                        payload_left = pkt_len;
                        queue_result(make_result(frame_kind, value, is_first, 1'b0));
                    end
                end else begin
                    hdr_pos = hdr_pos + 3'd1;
                    queue_result(make_result(frame_kind, value, is_first, 1'b0));
                end
            end
            PH_PAYLOAD: begin
                if (payload_left != 16'd0)
                    payload_left = payload_left - 16'd1;
                if (payload_left == 16'd0)
                    frame_phase = PH_IDLE;
                queue_result(make_result(frame_kind, value, 1'b0, payload_left == 16'd0));
            end
            default: begin
                // type indicator: first matching code wins, no match is a stray byte
                frame_phase = PH_IDLE;
                if (value == indicator_code[KIND_COMMAND])
                    frame_kind = KIND_COMMAND;
                else if (value == indicator_code[KIND_ACL])
                    frame_kind = KIND_ACL;
                else if (value == indicator_code[KIND_SYNC])
                    frame_kind = KIND_SYNC;
                else if (value == indicator_code[KIND_EVENT])
                    frame_kind = KIND_EVENT;
                else if (value == indicator_code[KIND_ISO])
                    frame_kind = KIND_ISO;
                else begin
                    queue_result(make_result(KIND_DROPPED, value, 1'b0, 1'b0));
                    return;
                end
                hdr_pos      = 3'd0;
                len_low      = 8'h00;
                payload_left = 16'd0;
                frame_phase  = PH_HEADER;
            end
        endcase
    endtask

    task automatic report_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
        mismatches++;
        $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
    endtask

    // Sample all channels at the clock edge
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            indicator_code[KIND_COMMAND] = RST_COMMAND;
            indicator_code[KIND_ACL]     = RST_ACL;
            indicator_code[KIND_SYNC]    = RST_SYNC;
            indicator_code[KIND_EVENT]   = RST_EVENT;
            indicator_code[KIND_ISO]     = RST_ISO;
            frame_phase  = PH_IDLE;
            frame_kind   = KIND_COMMAND;
            hdr_pos      = 3'd0;
            len_low      = 8'h00;
            payload_left = 16'd0;
            framed_bytes_q.delete();
        end else begin
            // code register writes; indexes past the last register are ignored
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_COMMAND: indicator_code[KIND_COMMAND] = i_cfg_data;
                    CFG_ACL:     indicator_code[KIND_ACL]     = i_cfg_data;
                    CFG_SYNC:    indicator_code[KIND_SYNC]    = i_cfg_data;
                    CFG_EVENT:   indicator_code[KIND_EVENT]   = i_cfg_data;
                    CFG_ISO:     indicator_code[KIND_ISO]     = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall)
                deframe_byte(i_in_byte);

            // result transaction against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (framed_bytes_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, got kind %h byte %h",
                             $time, i_packet_kind, i_out_byte);
                end else begin
                    want = framed_bytes_q.pop_front();
                    if (i_packet_kind !== want.packet_kind)
                        report_field("packet_kind", 8'(want.packet_kind), 8'(i_packet_kind));
                    if (i_out_byte !== want.out_byte)
                        report_field("out_byte", want.out_byte, i_out_byte);
                    if (i_first_of_packet !== want.first_of_packet)
                        report_field("first_of_packet", 8'(want.first_of_packet),
                                     8'(i_first_of_packet));
                    if (i_last_of_packet !== want.last_of_packet)
                        report_field("last_of_packet", 8'(want.last_of_packet),
                                     8'(i_last_of_packet));
                end
            end
        end
        o_pending    <= framed_bytes_q.size();
        o_mismatches <= mismatches;
    end

endmodule

>>> tb/hci_uart_packet_deframer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hci_uart_packet_deframer_tb
// Drives byte streams into the deframer: a short directed sequence covering
// every packet kind, stray bytes and zero-length packets, then mostly
// well-formed random packets with stray and truncated ones mixed in, under
// several code settings and idle/stall patterns. The checker does the
// prediction; this top gives the verdict.
// ----------------------------------------------------------------------------
module hci_uart_packet_deframer_tb;
    import hud_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BYTES  = 1600;
    localparam int NUM_CODE_SETS = 8;
    localparam int DRAIN_CYCLES  = 8;

    // Stray bytes, zero-length event, command, zero-length sync, ACL,
    // and an ISO header whose length is masked down to zero
    localparam logic [0:24][7:0] DIRECTED = {
        8'h00, 8'hFF,
        RST_EVENT, 8'h0E, 8'h00,
        RST_COMMAND, 8'h03, 8'h0C, 8'h01, 8'hA5,
        RST_SYNC, 8'h01, 8'h00, 8'h00,
        RST_ACL, 8'hFF, 8'h0F, 8'h01, 8'h00, 8'h5A,
        RST_ISO, 8'h00, 8'h00, 8'h00, 8'hC0
    };

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic       o_stall;
    logic [7:0] i_stream_byte = 8'h00;
    logic       o_valid;
    logic       i_stall       = 1'b0;
    logic [2:0] o_packet_kind;
    logic [7:0] o_out_byte;
    logic       o_first_of_packet;
    logic       o_last_of_packet;
    logic       i_cfg_valid   = 1'b0;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index   = 3'd0;
    logic [7:0] i_cfg_data    = 8'h00;

    int mismatch_count;
    int pending_results;

    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    int         bytes_sent    = 0;
    int         cycle_count   = 0;
    logic [7:0] active_code [5];

    hci_uart_packet_deframer DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_stream_byte     (i_stream_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_packet_kind     (o_packet_kind),
        .o_out_byte        (o_out_byte),
        .o_first_of_packet (o_first_of_packet),
        .o_last_of_packet  (o_last_of_packet),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    hci_uart_packet_deframer_checker checker_inst (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_in_byte         (i_stream_byte),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_packet_kind     (o_packet_kind),
        .i_out_byte        (o_out_byte),
        .i_first_of_packet (o_first_of_packet),
        .i_last_of_packet  (o_last_of_packet),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_mismatches      (mismatch_count),
        .o_pending         (pending_results)
    );

    always #5 i_clk = ~i_clk;

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // One byte transaction, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_stream_byte <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Mostly small packets; now and then a long one or a truncated one
    task automatic send_packet();
        int         kind;
        int         pkt_len;
        int         hdr_n;
        int         keep;
        int         roll;
        logic [7:0] hdr [4];
        kind = $urandom_range(int'(KIND_ISO));
        roll = $urandom_range(63);
        if (roll == 0)
            pkt_len = 255;
        else if (roll == 1 && kind == KIND_ACL)
            pkt_len = 256 + $urandom_range(15);
        else if (roll < 12)
            pkt_len = 0;
        else
            pkt_len = $urandom_range(12, 1);
        for (int k = 0; k < 4; k++)
            hdr[k] = 8'($urandom_range(255));
        if (kind == KIND_EVENT) begin
            hdr_n  = 2;
            hdr[1] = 8'(pkt_len);
        end else if (kind == KIND_COMMAND || kind == KIND_SYNC) begin
            hdr_n  = 3;
            hdr[2] = 8'(pkt_len);
        end else begin
            hdr_n  = 4;
            hdr[2] = 8'(pkt_len);
            hdr[3] = 8'(pkt_len >> 8);
            // top two length bits are don't-care for ISO
            if (kind == KIND_ISO)
                hdr[3][7:6] = 2'($urandom_range(3));
        end
        keep = hdr_n + pkt_len;
        if ($urandom_range(19) == 0)
            keep = $urandom_range(keep - 1);
        send_byte(active_code[kind]);
        for (int k = 0; k < keep; k++)
            send_byte(k < hdr_n ? hdr[k] : 8'($urandom_range(255)));
    endtask

    // Hold the input off until every predicted result is out and the pipe is empty
    task automatic wait_quiet();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx <= CFG_ISO)
            active_code[idx] = value;
    endtask

    // Code settings: extremes, overlapping codes, reset values, random, all equal
    task automatic program_codes(input int set_idx);
        logic [7:0] v [5];
        case (set_idx)
            1: v = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
            2: v = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF};
            3: v = '{RST_COMMAND, RST_ACL, RST_SYNC, RST_EVENT, RST_ISO};
            7: begin
                v[0] = 8'($urandom_range(255));
                for (int k = 1; k < 5; k++)
                    v[k] = v[0];
            end
            default: begin
                for (int k = 0; k < 5; k++)
                    v[k] = 8'($urandom_range(255));
            end
        endcase
        write_reg(CFG_COMMAND, v[KIND_COMMAND]);
        write_reg(CFG_ACL,     v[KIND_ACL]);
        write_reg(CFG_SYNC,    v[KIND_SYNC]);
        write_reg(CFG_EVENT,   v[KIND_EVENT]);
        write_reg(CFG_ISO,     v[KIND_ISO]);
        // index past the last register must leave the codes alone
        write_reg(3'(CFG_ISO + $urandom_range(3, 1)), 8'($urandom_range(255)));
        i_cfg_valid <= 1'b0;
    endtask

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("hci_uart_packet_deframer_tb: FAIL");
        $finish;
    end

    // Stimulus
    initial begin
        int target;
        active_code[KIND_COMMAND] = RST_COMMAND;
        active_code[KIND_ACL]     = RST_ACL;
        active_code[KIND_SYNC]    = RST_SYNC;
        active_code[KIND_EVENT]   = RST_EVENT;
        active_code[KIND_ISO]     = RST_ISO;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int set_idx = 0; set_idx < NUM_CODE_SETS; set_idx++) begin
            case (set_idx % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 57; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 57; end
                default: begin send_idle_pct = 25; stall_pct = 25; end
            endcase
            if (set_idx == 0) begin
                for (int k = 0; k < 25; k++)
                    send_byte(DIRECTED[k]);
            end else begin
                wait_quiet();
                program_codes(set_idx);
            end
            target = bytes_sent + RANDOM_BYTES / NUM_CODE_SETS;
            while (bytes_sent < target) begin
                if ($urandom_range(9) == 0) begin
                    // noise: a few raw bytes
                    repeat ($urandom_range(3, 1))
                        send_byte(8'($urandom_range(255)));
                end else begin
                    send_packet();
                end
            end
        end

        wait_quiet();
        if (mismatch_count == 0)
            $display("hci_uart_packet_deframer_tb: PASS");
        else
            $display("hci_uart_packet_deframer_tb: FAIL");
        $finish;
    end

endmodule
